[hdl/assert_macros.svh]
// Assertion macros shared by the RTL, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

[hdl/sws_pkg.sv]
// Types and constants for the shell word splitter.
`timescale 1ns / 1ps

package sws_pkg;

  localparam int NRES = 3;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_CMD   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_ESC   = 2'd1;
  localparam logic [1:0] ERR_QUOTE = 2'd2;

  // Quote modes
  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;

  // Escape phases
  localparam logic [2:0] ESC_IDLE = 3'd0;
  localparam logic [2:0] ESC_BS   = 3'd1;
  localparam logic [2:0] ESC_QBS  = 3'd2;
  localparam logic [2:0] ESC_OCT  = 3'd3;
  localparam logic [2:0] ESC_HEX0 = 3'd4;
  localparam logic [2:0] ESC_HEX1 = 3'd5;

  // Characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_XL     = 8'h78;
  localparam logic [7:0] CH_XU     = 8'h58;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] err;
    logic       last_out;
  } result_t;

  typedef result_t [NRES-1:0] bundle_t;

  typedef struct packed {
    logic [1:0] quote_mode;
    logic       prev_space;
    logic [2:0] escape_phase;
    logic [7:0] escape_acc;
    logic [1:0] digit_count;
  } state_t;

  localparam state_t ST_RESET = '{
    quote_mode:   Q_NONE,
    prev_space:   1'b1,
    escape_phase: ESC_IDLE,
    escape_acc:   8'd0,
    digit_count:  2'd0
  };

endpackage

[hdl/sws_step.sv]
// Per-byte splitting logic: next state and up to three results for one byte.
`timescale 1ns / 1ps

module sws_step (
  input  sws_pkg::state_t  st,
  input  sws_pkg::item_t   item,
  output sws_pkg::state_t  st_next,
  output logic [1:0]       count,
  output sws_pkg::bundle_t res
);
  import sws_pkg::*;

  typedef struct packed {
    state_t     s;
    logic [1:0] n;
    bundle_t    r;
  } work_t;

  function automatic result_t mk(logic [1:0] kind, logic [7:0] value, logic [1:0] err);
    result_t x;
    x.kind     = kind;
    x.value    = value;
    x.err      = err;
    x.last_out = 1'b0;
    return x;
  endfunction

  // Append a result; drop anything past the third.
  function automatic work_t push(work_t w, result_t x);
    work_t o;
    o = w;
    if (o.n != 2'd3) begin
      o.r[o.n] = x;
      o.n      = o.n + 2'd1;
    end
    return o;
  endfunction

  function automatic result_t byte_or_drop(logic [7:0] v);
    result_t x;
    x = (v == 8'd0) ? mk(KIND_BYTE, 8'd0, ERR_ESC) : mk(KIND_BYTE, v, ERR_NONE);
    return x;
  endfunction

  function automatic work_t finish(work_t w);
    work_t o;
    o = push(w, byte_or_drop(w.s.escape_acc));
    o.s.escape_phase = ESC_IDLE;
    o.s.escape_acc   = 8'd0;
    o.s.digit_count  = 2'd0;
    return o;
  endfunction

  function automatic logic [7:0] delim_of(logic [1:0] q);
    logic [7:0] d;
    d = (q == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
    return d;
  endfunction

  function automatic work_t plain(work_t w, logic [7:0] c);
    work_t o;
    o = w;
    if (o.s.quote_mode == Q_NONE) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        if (!o.s.prev_space) begin
          o = push(o, mk(KIND_END, 8'd0, ERR_NONE));
          o.s.prev_space = 1'b1;
        end
      end else begin
        if (o.s.prev_space) begin
          o = push(o, mk(KIND_START, 8'd0, ERR_NONE));
          o.s.prev_space = 1'b0;
        end
        if (c == CH_DQUOTE)      o.s.quote_mode = Q_DOUBLE;
        else if (c == CH_SQUOTE) o.s.quote_mode = Q_SINGLE;
        else if (c == CH_BSLASH) o.s.escape_phase = ESC_BS;
        else                     o = push(o, mk(KIND_BYTE, c, ERR_NONE));
      end
    end else begin
      if (c == delim_of(o.s.quote_mode)) o.s.quote_mode = Q_NONE;
      else if (c == CH_BSLASH)           o.s.escape_phase = ESC_QBS;
      else                               o = push(o, mk(KIND_BYTE, c, ERR_NONE));
    end
    return o;
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39)      h = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      h = {1'b1, c[3:0] + 4'd9};
    else                               h = 5'd0;
    return h;
  endfunction

  function automatic logic [7:0] named(logic [7:0] c);
    logic [7:0] v;
    unique case (c)
      8'h6E:   v = 8'd10;  // n
      8'h61:   v = 8'd7;   // a
      8'h62:   v = 8'd8;   // b
      8'h72:   v = 8'd13;  // r
      8'h66:   v = 8'd12;  // f
      8'h76:   v = 8'd11;  // v
      8'h74:   v = 8'd9;   // t
      default: v = c;
    endcase
    return v;
  endfunction

  work_t      w;
  logic [7:0] c;
  logic       is_oct;
  logic [4:0] h;
  logic [1:0] cmd_err;

  assign c      = item.ch;
  assign is_oct = (c[7:3] == 5'b00110);
  assign h      = hex_val(c);

  always_comb begin
    w   = '0;
    w.s = st;
    cmd_err = ERR_NONE;
    unique case (st.escape_phase)
      ESC_BS: begin
        if (is_oct) begin
          w.s.escape_acc   = {5'd0, c[2:0]};
          w.s.digit_count  = 2'd1;
          w.s.escape_phase = ESC_OCT;
        end else if (c == CH_XL || c == CH_XU) begin
          w.s.escape_acc   = 8'd0;
          w.s.escape_phase = ESC_HEX0;
        end else begin
          w.s.escape_phase = ESC_IDLE;
          w = push(w, byte_or_drop(named(c)));
        end
      end
      ESC_QBS: begin
        w.s.escape_phase = ESC_IDLE;
        if (c != delim_of(st.quote_mode)) w = push(w, mk(KIND_BYTE, CH_BSLASH, ERR_NONE));
        w = push(w, byte_or_drop(c));
      end
      ESC_OCT: begin
        if (is_oct) begin
          w.s.escape_acc  = {st.escape_acc[4:0], c[2:0]};
          w.s.digit_count = st.digit_count + 2'd1;
          if (st.digit_count >= 2'd2) w = finish(w);
        end else begin
          w = finish(w);
          w = plain(w, c);
        end
      end
      ESC_HEX0: begin
        if (h[4]) begin
          w.s.escape_acc   = {4'd0, h[3:0]};
          w.s.escape_phase = ESC_HEX1;
        end else begin
          w.s.escape_phase = ESC_IDLE;
          w.s.escape_acc   = 8'd0;
          w = push(w, mk(KIND_BYTE, 8'd0, ERR_ESC));
          w = plain(w, c);
        end
      end
      ESC_HEX1: begin
        if (h[4]) begin
          w.s.escape_acc = {st.escape_acc[3:0], h[3:0]};
          w = finish(w);
        end else begin
          w = finish(w);
          w = plain(w, c);
        end
      end
      default: begin
        w.s.escape_phase = ESC_IDLE;
        w = plain(w, c);
      end
    endcase

    if (item.last) begin
      // Complete a pending numeric escape, then close the command.
      if (w.s.escape_phase == ESC_OCT || w.s.escape_phase == ESC_HEX1) w = finish(w);
      if (w.s.quote_mode != Q_NONE) cmd_err = ERR_QUOTE;
      else if (w.s.escape_phase == ESC_BS || w.s.escape_phase == ESC_QBS ||
               w.s.escape_phase == ESC_HEX0) cmd_err = ERR_ESC;
      w = push(w, mk(KIND_CMD, 8'd0, cmd_err));
      w.s = ST_RESET;
    end

    if (w.n != 2'd0) w.r[w.n - 2'd1].last_out = 1'b1;
  end

  assign st_next = w.s;
  assign count   = w.n;
  assign res     = w.r;

endmodule

[hdl/shell_word_splitter.sv]
// Shell word splitter top level: input register, splitting logic, result drain.
// A byte is held in the input register, then its results are loaded into the result bundle that drives the port.
// Throughput: one byte per cycle while each byte gives at most one result and result_stall is low;
// a byte that gives several results holds the result port until its last result is taken.
// Reset: rst is synchronous; it clears the splitter state to "no argument open"
// and empties the input register and the result bundle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shell_word_splitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  sws_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output sws_pkg::result_t  result
);
  import sws_pkg::*;

  logic       s1_valid;
  item_t      s1;
  state_t     st;
  state_t     st_next;
  logic [1:0] step_n;
  bundle_t    step_r;
  bundle_t    bundle;
  logic [1:0] bcount;
  logic [1:0] bidx;
  logic       bvalid;
  logic       out_acc;
  logic       at_end;
  logic       load_ok;
  logic       fire;

  sws_step u_step (
    .st      (st),
    .item    (s1),
    .st_next (st_next),
    .count   (step_n),
    .res     (step_r)
  );

  assign at_end  = (bidx == bcount - 2'd1);
  assign out_acc = bvalid & ~result_stall;
  assign load_ok = ~bvalid | (out_acc & at_end);
  // A byte with no results never waits on the bundle.
  assign fire    = s1_valid & ((step_n == 2'd0) | load_ok);

  assign item_stall   = s1_valid & ~fire;
  assign result_valid = bvalid;
  assign result       = bundle[bidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || fire) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!s1_valid || fire) && item_valid) begin
      s1 <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      bcount <= 2'd0;
      bidx   <= 2'd0;
    end else if (fire && step_n != 2'd0) begin
      bvalid <= 1'b1;
      bcount <= step_n;
      bidx   <= 2'd0;
    end else if (out_acc) begin
      if (at_end) begin
        bvalid <= 1'b0;
      end else begin
        bidx <= bidx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step_n != 2'd0) begin
      bundle <= step_r;
    end
  end

  `ASSERT_IMPL(a_idx_in_range, bvalid, bidx < bcount, "result index past bundle count")
  `ASSERT_IMPL(a_last_mark, bvalid, result.last_out == at_end, "last_out not on final beat")
  `ASSERT_NEXT(a_cmd_reset, fire && s1.last, st == ST_RESET, "state not reset after command end")
  `ASSERT_IMPL(a_stall_held, item_stall, s1_valid, "input stalled with empty input register")

endmodule

[sim/sws_checker.sv]
// Checker for the shell word splitter: predicts every result beat and compares it.
`timescale 1ns / 1ps

module sws_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  sws_pkg::item_t    item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  sws_pkg::result_t  result,
  output int                fail_count,
  output int                awaited_count
);
  import sws_pkg::*;

  localparam logic [7:0] CH_0  = "0";
  localparam logic [7:0] CH_7  = "7";
  localparam logic [7:0] CH_9  = "9";
  localparam logic [7:0] CH_LA = "a";
  localparam logic [7:0] CH_LF = "f";
  localparam logic [7:0] CH_UA = "A";
  localparam logic [7:0] CH_UF = "F";

  // Predicted splitter state
  logic [1:0] quote_mode_q = Q_NONE;
  logic       arg_closed   = 1'b1;
  logic [2:0] esc_phase    = ESC_IDLE;
  logic [7:0] esc_val      = '0;
  logic [1:0] oct_digits   = '0;

  result_t byte_results[$];
  result_t awaited_results[$];
  int      fails = 0;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] escape_code(input logic [7:0] c);
    case (c)
      "n": return 8'd10;
      "a": return 8'd7;
      "b": return 8'd8;
      "r": return 8'd13;
      "f": return 8'd12;
      "v": return 8'd11;
      "t": return 8'd9;
      default: return c;
    endcase
  endfunction

  function automatic logic [7:0] closing_quote();
    return (quote_mode_q == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
  endfunction

  function automatic bit is_octal(input logic [7:0] c);
    return c >= CH_0 && c <= CH_7;
  endfunction

  task automatic clear_state();
    quote_mode_q = Q_NONE;
    arg_closed   = 1'b1;
    esc_phase    = ESC_IDLE;
    esc_val      = '0;
    oct_digits   = '0;
  endtask

  task automatic emit(input logic [1:0] k, input logic [7:0] v, input logic [1:0] e);
    if (byte_results.size() < NRES)
      byte_results.push_back('{kind: k, value: v, err: e, last_out: 1'b0});
  endtask

  // A zero value carries no byte and is flagged instead.
  task automatic close_escape();
    if (esc_val == 8'd0) emit(KIND_BYTE, 8'd0, ERR_ESC);
    else emit(KIND_BYTE, esc_val, ERR_NONE);
    esc_phase  = ESC_IDLE;
    esc_val    = '0;
    oct_digits = '0;
  endtask

  task automatic plain_byte(input logic [7:0] c);
    if (quote_mode_q == Q_NONE) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        if (!arg_closed) begin
          emit(KIND_END, 8'd0, ERR_NONE);
          arg_closed = 1'b1;
        end
      end else begin
        if (arg_closed) begin
          emit(KIND_START, 8'd0, ERR_NONE);
          arg_closed = 1'b0;
        end
        if (c == CH_DQUOTE) quote_mode_q = Q_DOUBLE;
        else if (c == CH_SQUOTE) quote_mode_q = Q_SINGLE;
        else if (c == CH_BSLASH) esc_phase = ESC_BS;
        else emit(KIND_BYTE, c, ERR_NONE);
      end
    end else begin
      if (c == closing_quote()) quote_mode_q = Q_NONE;
      else if (c == CH_BSLASH) esc_phase = ESC_QBS;
      else emit(KIND_BYTE, c, ERR_NONE);
    end
  endtask

  task automatic take_byte(input logic [7:0] c);
    int h;
    h = hex_digit(c);
    case (esc_phase)
      ESC_BS: begin
        if (is_octal(c)) begin
          esc_val    = {5'd0, c[2:0]};
          oct_digits = 2'd1;
          esc_phase  = ESC_OCT;
        end else if (c == CH_XL || c == CH_XU) begin
          esc_val   = '0;
          esc_phase = ESC_HEX0;
        end else begin
          esc_phase = ESC_IDLE;
          if (escape_code(c) == 8'd0) emit(KIND_BYTE, 8'd0, ERR_ESC);
          else emit(KIND_BYTE, escape_code(c), ERR_NONE);
        end
      end
      ESC_QBS: begin
        esc_phase = ESC_IDLE;
        if (c != closing_quote()) emit(KIND_BYTE, CH_BSLASH, ERR_NONE);
        if (c == 8'd0) emit(KIND_BYTE, 8'd0, ERR_ESC);
        else emit(KIND_BYTE, c, ERR_NONE);
      end
      ESC_OCT: begin
        if (is_octal(c)) begin
          esc_val    = {esc_val[4:0], c[2:0]};
          oct_digits = oct_digits + 2'd1;
          if (oct_digits == 2'd3) close_escape();
        end else begin
          close_escape();
          plain_byte(c);
        end
      end
      ESC_HEX0: begin
        if (h >= 0) begin
          esc_val   = h[7:0];
          esc_phase = ESC_HEX1;
        end else begin
          esc_phase = ESC_IDLE;
          esc_val   = '0;
          emit(KIND_BYTE, 8'd0, ERR_ESC);
          plain_byte(c);
        end
      end
      ESC_HEX1: begin
        if (h >= 0) begin
          esc_val = {esc_val[3:0], h[3:0]};
          close_escape();
        end else begin
          close_escape();
          plain_byte(c);
        end
      end
      default: begin
        esc_phase = ESC_IDLE;
        plain_byte(c);
      end
    endcase
  endtask

  task automatic split_byte(input item_t it);
    logic [1:0] end_err;
    result_t    r;
    byte_results.delete();
    take_byte(it.ch);
    if (it.last) begin
      // finish a pending numeric escape before the command-end beat
      if (esc_phase == ESC_OCT || esc_phase == ESC_HEX1) close_escape();
      if (quote_mode_q != Q_NONE) end_err = ERR_QUOTE;
      else if (esc_phase == ESC_BS || esc_phase == ESC_QBS || esc_phase == ESC_HEX0)
        end_err = ERR_ESC;
      else end_err = ERR_NONE;
      emit(KIND_CMD, 8'd0, end_err);
      clear_state();
    end
    for (int i = 0; i < byte_results.size(); i++) begin
      r = byte_results[i];
      r.last_out = (i == byte_results.size() - 1);
      awaited_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_state();
      awaited_results.delete();
    end else begin
      if (item_valid && !item_stall) split_byte(item);
      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected beat: kind %0d value %0d err %0d", result.kind, result.value,
                 result.err);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", want.kind, result.kind);
          check_field("value", want.value, result.value);
          check_field("err", want.err, result.err);
          check_field("last_out", want.last_out, result.last_out);
        end
      end
    end
    fail_count    <= fails;
    awaited_count <= awaited_results.size();
  end

endmodule

[sim/shell_word_splitter_tb.sv]
// Testbench top for the shell word splitter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module shell_word_splitter_tb;
  import sws_pkg::*;

  localparam int RANDOM_ITEMS = 250;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  item_t   item         = '0;
  logic    result_stall = 1'b0;
  logic    item_stall;
  logic    result_valid;
  result_t result;

  int fail_count;
  int awaited_count;
  bit calm        = 1'b0;
  int stall_left  = 0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  shell_word_splitter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  sws_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  // Mostly no gap, some short ones, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Weighted toward separators, quotes, backslashes and escape digits.
  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return CH_SPACE;
    if (r < 16) return CH_TAB;
    if (r < 22) return CH_DQUOTE;
    if (r < 28) return CH_SQUOTE;
    if (r < 40) return CH_BSLASH;
    if (r < 52) return 8'($urandom_range("0", "7"));
    if (r < 56) return 8'($urandom_range("8", "9"));
    if (r < 62) return $urandom_range(0, 1) ? CH_XL : CH_XU;
    if (r < 66) return 8'($urandom_range("a", "f"));
    if (r < 70) return 8'($urandom_range("A", "F"));
    if (r < 76) begin
      case ($urandom_range(0, 6))
        0: return "n";
        1: return "a";
        2: return "b";
        3: return "r";
        4: return "f";
        5: return "v";
        default: return "t";
      endcase
    end
    if (r < 80) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic l);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{ch: c, last: l};
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s, input bit ends_cmd);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], ends_cmd && (i == s.len() - 1));
  endtask

  // Random stalls on the result side; no new stall run starts while calm.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else begin
      result_stall <= 1'b0;
      if (!calm) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // whitespace run, octal escape, x with no hex digit
    send_text("a \t\\101\\xg", 1'b1);
    // quoted escapes, other quote inside, quote left open at the end
    send_text("'x\\'\\q\"", 1'b1);
    // backslash waiting at the end
    send_text("\\", 1'b1);
    // top byte, escaped zero byte, octal zero, command ending on a space
    send_byte(8'hFF, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("\\0 ", 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_byte(random_char(), $urandom_range(0, 14) == 0);
    end
    calm = 1'b0;
    item_valid <= 1'b0;

    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/sws_pkg.sv
hdl/sws_step.sv
hdl/shell_word_splitter.sv
sim/sws_checker.sv
sim/shell_word_splitter_tb.sv
